>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the tone burst peak detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/tbpd_pkg.sv
// Package with the types and constants of the tone burst peak detector.
`timescale 1ns / 1ps
`default_nettype none
package tbpd_pkg;

	// Field widths.
	localparam int SAMPLE_BITS = 10;
	localparam int TIME_BITS   = 32;
	localparam int DC_W        = 10;
	localparam int FREQ_W      = 10;
	localparam int HITS_W      = 8;
	localparam int WIN_W       = 16;
	localparam int STATUS_W    = 2;

	// Frequency is FREQ_SCALE divided by the peak interval in milliseconds.
	localparam int FREQ_SCALE = 1000;
	localparam int QUO_W      = 10;
	localparam int CNT_W      = $clog2(QUO_W);

	// Configuration port.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_W   = 3;
	localparam logic [REG_W-1:0] REG_DC_OFFSET = 3'd0;
	localparam logic [REG_W-1:0] REG_TARGET    = 3'd1;
	localparam logic [REG_W-1:0] REG_TOLERANCE = 3'd2;
	localparam logic [REG_W-1:0] REG_HITS      = 3'd3;
	localparam logic [REG_W-1:0] REG_WINDOW    = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_LISTEN  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DETECT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd3;

	// Input action codes.
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic                   action;
		logic [SAMPLE_BITS-1:0] sample;
		logic [TIME_BITS-1:0]   time_now;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HITS_W-1:0]   hit_total;
	} out_t;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/tone_burst_peak_detector_unit.sv
// Top level of the tone burst peak detector with sequencer and register file.
//
// Usage: the in channel (in_valid/in_ready/in_data) carries one item per
// transfer: a start action opens a listening window at time_now, a sample
// action presents one converter reading. Every input item yields exactly one
// result on the out channel (out_valid/out_ready/out_data) with the status
// and the match count of the current window.
// The block handles one item at a time. A start item, a sample while idle or
// a sample after the window expired goes from the window check straight to
// the final step; a sample that is no peak or a peak in the same millisecond
// as the last one also runs the sample and peak steps; a peak with a nonzero
// interval runs the serial divider, one quotient bit per cycle over 10 bits,
// and then the match step. in_ready is high only while the sequencer is idle,
// from the cycle after the result is loaded.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the following result holds in the final
// step until the output register frees up.
// Reset clears the window state and loads the register defaults; the
// configuration registers are read and written through the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tone_burst_peak_detector_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tbpd_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tbpd_pkg::out_t                   out_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tbpd_pkg::PADDR_W-1:0]     paddr,
	input  logic [tbpd_pkg::PDATA_W-1:0]     pwdata,
	output logic [tbpd_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import tbpd_pkg::*;

	localparam int CUR_W = ((SAMPLE_BITS > DC_W) ? SAMPLE_BITS : DC_W) + 1;
	localparam int CMP_W = CUR_W + 3;
	localparam int ERR_W = FREQ_W + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WIN   = 3'd1;
	localparam logic [2:0] S_SAMP  = 3'd2;
	localparam logic [2:0] S_PEAK  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_MATCH = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	// Configuration registers.
	logic [DC_W-1:0]   dc_offset_q;
	logic [FREQ_W-1:0] target_q;
	logic [FREQ_W-1:0] tol_q;
	logic [HITS_W-1:0] hits_needed_q;
	logic [WIN_W-1:0]  window_q;

	// Window state.
	logic                   active_q;
	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   peak_q;
	logic [CUR_W-1:0]       prev_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [HITS_W-1:0]      hit_q;

	// Sequencer and item registers.
	logic [2:0]          state_q;
	in_t                 item_q;
	logic [CUR_W-1:0]    cur_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	out_t                out_q;

	logic                 cfg_wr;
	logic [REG_W-1:0]     reg_idx;
	logic                 in_xfer;
	logic                 load_out;
	logic [TIME_BITS-1:0] win_diff;
	logic                 expired;
	logic [CUR_W-1:0]     cur_w;
	logic                 cur_gt_max;
	logic signed [CMP_W-1:0] prev4;
	logic signed [CMP_W-1:0] max_ext;
	logic signed [CMP_W-1:0] max3;
	logic                 is_peak;
	logic [TIME_BITS-1:0] dt;
	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]     err_abs;
	logic                 is_match;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic [QUO_W-1:0]     quotient;

	// Configuration port: writes on the access phase, reads decode the address.
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q   <= DC_W'(287);
			target_q      <= FREQ_W'(1000);
			tol_q         <= FREQ_W'(50);
			hits_needed_q <= HITS_W'(5);
			window_q      <= WIN_W'(500);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DC_OFFSET: dc_offset_q   <= pwdata[DC_W-1:0];
				REG_TARGET:    target_q      <= pwdata[FREQ_W-1:0];
				REG_TOLERANCE: tol_q         <= pwdata[FREQ_W-1:0];
				REG_HITS:      hits_needed_q <= pwdata[HITS_W-1:0];
				REG_WINDOW:    window_q      <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DC_OFFSET: prdata = PDATA_W'(dc_offset_q);
			REG_TARGET:    prdata = PDATA_W'(target_q);
			REG_TOLERANCE: prdata = PDATA_W'(tol_q);
			REG_HITS:      prdata = PDATA_W'(hits_needed_q);
			REG_WINDOW:    prdata = PDATA_W'(window_q);
			default:       prdata = '0;
		endcase
	end

	// Handshakes.
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Window check and sample centering.
	assign win_diff = item_q.time_now - start_q;
	assign expired  = (win_diff > TIME_BITS'(window_q));
	assign cur_w    = CUR_W'(item_q.sample) - CUR_W'(dc_offset_q);

	// Running maximum and three-quarter peak test.
	assign cur_gt_max = ($signed(cur_q) > $signed(CUR_W'(max_q)));
	assign prev4      = CMP_W'($signed(prev_q)) <<< 2;
	assign max_ext    = $signed(CMP_W'(max_q));
	assign max3       = (max_ext <<< 1) + max_ext;
	assign is_peak    = ($signed(cur_q) < $signed(prev_q)) && (prev4 >= max3);
	assign dt         = item_q.time_now - peak_q;

	// Distance of the measured frequency from the target.
	assign err      = $signed({1'b0, quotient}) - $signed({1'b0, target_q});
	assign err_abs  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign is_match = (err_abs < {1'b0, tol_q});

	assign div_req.start = (state_q == S_PEAK) && is_peak && (dt != '0);

	tbpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.divisor  (dt),
		.rsp      (div_rsp),
		.quotient (quotient)
	);

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= 1'b0;
			start_q      <= '0;
			peak_q       <= '0;
			prev_q       <= '0;
			max_q        <= '0;
			hit_q        <= '0;
			res_status_q <= ST_LISTEN;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (item_q.action == ACT_START) begin
						active_q     <= 1'b1;
						start_q      <= item_q.time_now;
						peak_q       <= item_q.time_now;
						prev_q       <= '0;
						max_q        <= '0;
						hit_q        <= '0;
						res_status_q <= ST_LISTEN;
						state_q      <= S_DONE;
					end else if (!active_q) begin
						res_status_q <= ST_IDLE;
						state_q      <= S_DONE;
					end else if (expired) begin
						active_q     <= 1'b0;
						res_status_q <= ST_TIMEOUT;
						state_q      <= S_DONE;
					end else begin
						res_status_q <= ST_LISTEN;
						state_q      <= S_SAMP;
					end
				end
				S_SAMP: begin
					if (cur_gt_max) begin
						max_q <= cur_q[SAMPLE_BITS-1:0];
					end
					state_q <= S_PEAK;
				end
				S_PEAK: begin
					prev_q <= cur_q;
					if (is_peak) begin
						peak_q <= item_q.time_now;
					end
					state_q <= div_req.start ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (is_match) begin
						if (hit_q == hits_needed_q) begin
							active_q     <= 1'b0;
							res_status_q <= ST_DETECT;
						end else if (hit_q != '1) begin
							hit_q <= hit_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item and centered sample registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q <= in_data;
		end
		if (state_q == S_WIN) begin
			cur_q <= cur_w;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status    <= res_status_q;
			out_q.hit_total <= hit_q;
		end
	end

	// An accepted item always starts with the window check.
	`ASSERT_NEXT(a_xfer_to_win, clk, arst_n, in_xfer, state_q == S_WIN)
	// The divider finishes only while the sequencer waits for it.
	`ASSERT_SAME(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV)
	// A detection result always leaves the window closed.
	`ASSERT_NEXT(a_detect_closes, clk, arst_n,
		load_out && (res_status_q == ST_DETECT), !active_q)
	// The match count only steps by one or clears.
	`ASSERT_SAME(a_hit_step, clk, arst_n, hit_q != $past(hit_q),
		(hit_q == $past(hit_q) + 8'd1) || (hit_q == '0))

endmodule
`default_nettype wire

>>> hdl/tbpd_div.sv
// Serial restoring divider computing the scale constant over the peak interval.
`timescale 1ns / 1ps
`default_nettype none
module tbpd_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  tbpd_pkg::div_req_t               req,
	input  logic [tbpd_pkg::TIME_BITS-1:0]   divisor,
	output tbpd_pkg::div_rsp_t               rsp,
	output logic [tbpd_pkg::QUO_W-1:0]       quotient
);
	import tbpd_pkg::*;

	localparam logic [QUO_W-1:0] DIVIDEND = QUO_W'(FREQ_SCALE);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TIME_BITS-1:0] div_q;
	logic [QUO_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;

	logic [QUO_W:0]       rem_sh;
	logic [TIME_BITS-1:0] rem_ext;
	logic [TIME_BITS-1:0] rem_sub;
	logic                 ge;
	logic [QUO_W-1:0]     rem_next;

	// One quotient bit per cycle: shift in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh   = {rem_q, DIVIDEND[cnt_q]};
		rem_ext  = TIME_BITS'(rem_sh);
		ge       = (rem_ext >= div_q);
		rem_sub  = rem_ext - div_q;
		rem_next = ge ? rem_sub[QUO_W-1:0] : rem_sh[QUO_W-1:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
